// File: hw/rtl/shrm_pkg.sv
// Shared types and constants for the sample history ring with maximum query.
// Holds the word formats, the opcode codes and the control/status bundles.
// Depends on nothing; every other file in this folder imports it.
`default_nettype none

package shrm_pkg;

    // Default sizes of the ring store.
    localparam int DEPTH_DEFAULT       = 64;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // Fixed field widths of the channel words.
    localparam int FIELD_BITS = 16;
    localparam int OP_BITS    = 2;
    localparam int LEN_BITS   = 7;

    // Length register value after reset.
    localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd64;

    // Opcodes; the fourth code is unused and answers zero.
    localparam logic [OP_BITS-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_BITS-1:0] OP_READ = 2'd1;
    localparam logic [OP_BITS-1:0] OP_MAX  = 2'd2;

    // Input word.
    typedef struct packed {
        logic [OP_BITS-1:0]           opcode;
        logic [FIELD_BITS-1:0]        sample;
        logic signed [FIELD_BITS-1:0] age;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [FIELD_BITS-1:0] read_value;
        logic                  out_of_range;
    } out_word_t;

    // Source of the pending result.
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FLAG,
        RES_RDATA,
        RES_MAX
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     push;
        logic     read_issue;
        logic     scan_clear;
        logic     scan_issue;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_BITS-1:0] opcode;
        logic               read_ok;
        logic               scan_last;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/shrm_datapath.sv
// Datapath of the sample history ring: sample store, newest pointer, length
// register, scan counter, maximum accumulator, result and output registers.
// Depends on shrm_pkg; driven by shrm_ctrl through dp_cmd_t.
`default_nettype none

module shrm_datapath
    import shrm_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire in_word_t            s_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [LEN_BITS-1:0] cfg_wr_data,
    input  wire dp_cmd_t             cmd,
    output dp_status_t               status,
    output out_word_t                m_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > LEN_BITS) ? LW : LEN_BITS;

    // Store and per-entry valid bits; an entry never written reads as zero.
    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]       valid_reg, valid_next;

    logic [LEN_BITS-1:0]    length_reg;
    logic [IW-1:0]          newest_reg, newest_next;
    in_word_t               item_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [IW-1:0]          cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [FIELD_BITS-1:0]  acc_reg, acc_next;
    out_word_t              res_reg;
    out_word_t              out_reg;

    logic [CW-1:0]          len_ext;
    logic [CW-1:0]          eff_len;
    logic [CW-1:0]          push_nxt;
    logic [IW-1:0]          push_slot;
    logic [CW-1:0]          age_c;
    logic [CW-1:0]          newest_c;
    logic [CW-1:0]          diff_c;
    logic [CW:0]            wrap_c;
    logic [IW-1:0]          read_slot;
    logic [IW-1:0]          rd_addr;
    logic                   rd_en;
    logic [FIELD_BITS-1:0]  rdata_eff;
    logic [FIELD_BITS-1:0]  acc_max;

    // Effective length: the register saturated into 1..DEPTH.
    always_comb begin
        len_ext = CW'(length_reg);
        if (len_ext == '0) begin
            eff_len = CW'(1);
        end else if (len_ext > CW'(DEPTH)) begin
            eff_len = CW'(DEPTH);
        end else begin
            eff_len = len_ext;
        end
    end

    // Push slot: one past the newest, wrapping at the length.
    always_comb begin
        push_nxt = CW'(newest_reg) + CW'(1);
        if (push_nxt >= eff_len) begin
            push_slot = '0;
        end else begin
            push_slot = push_nxt[IW-1:0];
        end
    end

    // Read slot for an age that lies inside the ring.
    always_comb begin
        age_c    = item_reg.age[CW-1:0];
        newest_c = CW'(newest_reg);
        diff_c   = newest_c - age_c;
        wrap_c   = {1'b0, newest_c} + {1'b0, eff_len} - {1'b0, age_c};
        if (newest_c >= age_c) begin
            read_slot = diff_c[IW-1:0];
        end else begin
            read_slot = wrap_c[IW-1:0];
        end
    end

    // Status toward the controller.
    always_comb begin
        status.opcode    = item_reg.opcode;
        status.read_ok   = !item_reg.age[FIELD_BITS-1] &&
                           (item_reg.age < $signed(FIELD_BITS'(eff_len)));
        status.scan_last = (CW'(cnt_reg) == (eff_len - CW'(1)));
    end

    // Read port address: a single read or the scan counter.
    assign rd_addr = cmd.read_issue ? read_slot : cnt_reg;
    assign rd_en   = cmd.read_issue || cmd.scan_issue;

    // Sample store: one write or one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[push_slot] <= SAMPLE_BITS'(item_reg.sample);
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Valid bits and newest pointer follow each push.
    always_comb begin
        valid_next  = valid_reg;
        newest_next = newest_reg;
        if (cmd.push) begin
            valid_next[push_slot] = 1'b1;
            newest_next           = push_slot;
        end
    end

    // Scan bookkeeping and running maximum.
    assign rdata_eff = rd_valid_reg ? FIELD_BITS'(rd_data_reg) : '0;
    assign acc_max   = (pend_reg && (rdata_eff > acc_reg)) ? rdata_eff : acc_reg;

    always_comb begin
        cnt_next  = cnt_reg;
        acc_next  = acc_max;
        pend_next = cmd.scan_issue;
        if (cmd.scan_clear) begin
            cnt_next = '0;
            acc_next = '0;
        end else if (cmd.scan_issue) begin
            cnt_next = cnt_reg + IW'(1);
        end
    end

    // Control state: length, pointer and valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= LEN_RESET;
            newest_reg <= '0;
            valid_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                length_reg <= cfg_wr_data;
            end
            newest_reg <= newest_next;
            valid_reg  <= valid_next;
        end
    end

    // Payload registers: captured word, scan state, result and output word.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        pend_reg <= pend_next;
        if (cmd.res_load) begin
            case (cmd.res_sel)
                RES_ZERO: res_reg <= '{read_value: '0, out_of_range: 1'b0};
                RES_FLAG: res_reg <= '{read_value: '0, out_of_range: 1'b1};
                RES_RDATA: res_reg <= '{read_value: rdata_eff, out_of_range: 1'b0};
                RES_MAX: res_reg <= '{read_value: acc_max, out_of_range: 1'b0};
                default: res_reg <= '{read_value: '0, out_of_range: 1'b0};
            endcase
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/shrm_ctrl.sv
// Controller of the sample history ring: sequences push, read and maximum
// scan, and owns the input ready and the output valid.
// Depends on shrm_pkg; commands shrm_datapath through dp_cmd_t.
`default_nettype none

module shrm_ctrl
    import shrm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDATA,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next state, commands and output valid.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.res_sel  = RES_ZERO;

        // The output word leaves when it is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.opcode)
                    OP_PUSH: begin
                        cmd.push     = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_ZERO;
                        state_next   = ST_EMIT;
                    end
                    OP_READ: begin
                        if (status.read_ok) begin
                            cmd.read_issue = 1'b1;
                            state_next     = ST_RDATA;
                        end else begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_FLAG;
                            state_next   = ST_EMIT;
                        end
                    end
                    OP_MAX: begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_ZERO;
                        state_next   = ST_EMIT;
                    end
                endcase
            end
            ST_RDATA: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_RDATA;
                state_next   = ST_EMIT;
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_MAX;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sample_history_ring_with_max_core.sv
// Top level of the sample history ring with maximum query.
// Instantiates shrm_ctrl and shrm_datapath; depends on shrm_pkg.
//
//   Channel  Ports                         Carries
//   input    s_valid, s_ready, s_data      in_word_t: opcode, sample, age
//   result   m_valid, m_ready, m_data      out_word_t: read_value, out_of_range
//   config   cfg_wr_en, cfg_wr_data        length_in_use, written without wait
//
// A push, an unknown opcode or a read with a bad age loads its result in the
// execute state, a good read in the read-data state, and a maximum query in
// the drain state after the scan over the effective length, which reads one
// store entry per cycle through the single port. The emit state moves the
// result into the output register and returns to idle to take the next word.
// One word is in work at a time; a new word is accepted while the last result
// still waits in the output register. A stalled output holds the next result.
// Reset clears the store through per-entry valid bits at once, with no sweep.
`default_nettype none

module sample_history_ring_with_max_core
    import shrm_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_word_t            s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_word_t                m_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [LEN_BITS-1:0] cfg_wr_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    shrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Store, pointer and result registers.
    shrm_datapath #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// File: dv/ring_result_checker.sv
// Result checker for the sample history ring with maximum query.
// Watches both channels and the length write port, predicts each result word.
// Depends on shrm_pkg for the word formats and the opcode codes.
module ring_result_checker
    import shrm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  in_word_t            s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  out_word_t           m_data,
    input  logic                cfg_wr_en,
    input  logic [LEN_BITS-1:0] cfg_wr_data,
    output int                  words_pending,
    output int                  fail_count
);

    localparam int RING_SLOTS = DEPTH_DEFAULT;

    // Shadow copy of the ring, its newest pointer and the length register.
    logic [FIELD_BITS-1:0] ring_copy [RING_SLOTS];
    int                    head_slot;
    logic [LEN_BITS-1:0]   length_reg;
    out_word_t             due_words [$];

    // The length register saturates into 1..RING_SLOTS.
    function automatic int active_length();
        if (length_reg == 0) begin
            return 1;
        end
        if (length_reg > RING_SLOTS) begin
            return RING_SLOTS;
        end
        return int'(length_reg);
    endfunction

    // Applies one input word to the shadow state and returns its result word.
    function automatic out_word_t apply_word(input in_word_t w);
        out_word_t r;
        int        len;
        int        next;
        int        age_u;
        int        slot;
        r     = '0;
        len   = active_length();
        age_u = int'(w.age[FIELD_BITS-2:0]);
        case (w.opcode)
            OP_PUSH: begin
                next = head_slot + 1;
                if (next >= len) begin
                    next = 0;
                end
                head_slot       = next;
                ring_copy[next] = w.sample;
            end
            OP_READ: begin
                // A negative age or one at or past the length is flagged.
                if (w.age[FIELD_BITS-1] || age_u >= len) begin
                    r.out_of_range = 1'b1;
                end else begin
                    // The pointer may sit past a shrunken length; the slot
                    // still stays inside the store.
                    if (head_slot >= age_u) begin
                        slot = head_slot - age_u;
                    end else begin
                        slot = head_slot + len - age_u;
                    end
                    r.read_value = ring_copy[slot];
                end
            end
            OP_MAX: begin
                for (int i = 0; i < len; i++) begin
                    if (ring_copy[i] > r.read_value) begin
                        r.read_value = ring_copy[i];
                    end
                end
            end
            default: begin
                // The unused code changes nothing and answers zero.
            end
        endcase
        return r;
    endfunction

    // Results are popped before the word accepted at the same edge is added.
    always @(posedge aclk) begin
        out_word_t due;
        if (!aresetn) begin
            for (int i = 0; i < RING_SLOTS; i++) begin
                ring_copy[i] = '0;
            end
            head_slot  = 0;
            length_reg = LEN_RESET;
            due_words.delete();
            words_pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                length_reg = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (due_words.size() == 0) begin
                    $error("result word with nothing due: read_value %h out_of_range %b",
                           m_data.read_value, m_data.out_of_range);
                    fail_count++;
                end else begin
                    due = due_words.pop_front();
                    if (m_data.read_value !== due.read_value) begin
                        $error("read_value: expected %h, actual %h",
                               due.read_value, m_data.read_value);
                        fail_count++;
                    end
                    if (m_data.out_of_range !== due.out_of_range) begin
                        $error("out_of_range: expected %b, actual %b",
                               due.out_of_range, m_data.out_of_range);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                due_words.push_back(apply_word(s_data));
            end
            words_pending <= due_words.size();
        end
    end

endmodule

// File: dv/tb_sample_history_ring_with_max_core.sv
// Testbench top for sample_history_ring_with_max_core.
// Drives directed and random words and length writes; ring_result_checker
// predicts and compares. Depends on shrm_pkg and the core RTL.
module tb_sample_history_ring_with_max_core;
    import shrm_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 10;
    localparam int SEG_WORDS    = 100;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    in_word_t            s_data      = '0;
    logic                m_ready     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [LEN_BITS-1:0] cfg_wr_data = '0;
    logic                s_ready;
    logic                m_valid;
    out_word_t           m_data;
    int                  words_pending;
    int                  fail_count;
    int                  send_idle_pct = 16;
    int                  recv_idle_pct = 70;
    int                  quiet_cycles  = 0;

    always #10 aclk = ~aclk;

    sample_history_ring_with_max_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ring_result_checker result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .words_pending (words_pending),
        .fail_count    (fail_count)
    );

    // The receiver stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: too long without any word moving on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic in_word_t make_word(input logic [OP_BITS-1:0] op,
                                           input logic [FIELD_BITS-1:0] smp,
                                           input logic [FIELD_BITS-1:0] age);
        in_word_t w;
        w.opcode = op;
        w.sample = smp;
        w.age    = age;
        return w;
    endfunction

    // Mostly pushes and in-range reads, with some max queries, bad ages and
    // the unused opcode.
    function automatic in_word_t random_word(input int len);
        in_word_t w;
        int       pick;
        int       age_kind;
        pick     = $urandom_range(99);
        age_kind = $urandom_range(9);
        if ($urandom_range(9) == 0) begin
            w.sample = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end else begin
            w.sample = 16'($urandom);
        end
        if (age_kind < 7) begin
            w.age = 16'($urandom_range(len - 1));
        end else if (age_kind == 7) begin
            w.age = 16'(len + $urandom_range(2));
        end else begin
            w.age = 16'($urandom);
        end
        if (pick < 45) begin
            w.opcode = OP_PUSH;
        end else if (pick < 83) begin
            w.opcode = OP_READ;
        end else if (pick < 94) begin
            w.opcode = OP_MAX;
        end else begin
            w.opcode = OP_UNUSED;
        end
        return w;
    endfunction

    // Presents one word after a random gap and holds it until accepted.
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // The length is written only once every result word has come back.
    task automatic set_length(input logic [LEN_BITS-1:0] value);
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [LEN_BITS-1:0] len_plan [9];
        int                  eff;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty ring, age extremes, sample extremes, unused opcode.
        send_word(make_word(OP_MAX, 16'h1111, 16'h0000));
        send_word(make_word(OP_READ, 16'h0000, 16'd0));
        send_word(make_word(OP_READ, 16'hFFFF, 16'd63));
        send_word(make_word(OP_READ, 16'h0000, 16'd64));
        send_word(make_word(OP_READ, 16'h0000, 16'hFFFF));
        send_word(make_word(OP_READ, 16'h0000, 16'h8000));
        send_word(make_word(OP_READ, 16'h0000, 16'h7FFF));
        send_word(make_word(OP_PUSH, 16'hFFFF, 16'hFFFF));
        send_word(make_word(OP_PUSH, 16'h0000, 16'h8000));
        send_word(make_word(OP_PUSH, 16'h8000, 16'h0000));
        send_word(make_word(OP_PUSH, 16'h7FFF, 16'h7FFF));
        send_word(make_word(OP_READ, 16'h0000, 16'd0));
        send_word(make_word(OP_READ, 16'h0000, 16'd3));
        send_word(make_word(OP_READ, 16'h0000, 16'd4));
        send_word(make_word(OP_MAX, 16'h0000, 16'h0000));
        send_word(make_word(OP_UNUSED, 16'hFFFF, 16'hFFFF));

        // Shrink the length below the newest pointer, then wrap it.
        set_length(7'd3);
        send_word(make_word(OP_READ, 16'h0000, 16'd0));
        send_word(make_word(OP_READ, 16'h0000, 16'd2));
        send_word(make_word(OP_READ, 16'h0000, 16'd3));
        send_word(make_word(OP_MAX, 16'h0000, 16'h0000));
        send_word(make_word(OP_PUSH, 16'h1234, 16'h0000));
        send_word(make_word(OP_READ, 16'h0000, 16'd0));

        // A zero length acts as one slot.
        set_length(7'd0);
        send_word(make_word(OP_PUSH, 16'hABCD, 16'h0000));
        send_word(make_word(OP_READ, 16'h0000, 16'd1));
        send_word(make_word(OP_MAX, 16'h0000, 16'h0000));

        // Random segments, each under its own length setting.
        len_plan[0] = 7'd1;
        len_plan[1] = 7'd64;
        len_plan[2] = 7'd0;
        len_plan[3] = 7'd127;
        len_plan[4] = 7'd2;
        len_plan[5] = 7'($urandom_range(3, 63));
        len_plan[6] = 7'd65;
        len_plan[7] = 7'($urandom_range(1, 64));
        len_plan[8] = 7'd64;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                set_length(len_plan[phase * 3 + seg]);
                eff = int'(len_plan[phase * 3 + seg]);
                if (eff < 1) begin
                    eff = 1;
                end else if (eff > DEPTH_DEFAULT) begin
                    eff = DEPTH_DEFAULT;
                end
                repeat (SEG_WORDS) send_word(random_word(eff));
            end
        end

        // Drain the outstanding results, then give the verdict.
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/shrm_pkg.sv
hw/rtl/shrm_datapath.sv
hw/rtl/shrm_ctrl.sv
hw/rtl/sample_history_ring_with_max_core.sv
dv/ring_result_checker.sv
dv/tb_sample_history_ring_with_max_core.sv
